[rtl/mau_pkg.sv]
// Package with the shared width, operation codes, types and modular add and subtract helpers.
`default_nettype none
package mau_pkg;
  localparam int W = 32;
  localparam int CNT_W = $clog2(W);

  typedef logic [W-1:0] word_t;
  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_ADD = 3'd0;
  localparam opcode_t OP_SUB = 3'd1;
  localparam opcode_t OP_MUL = 3'd2;
  localparam opcode_t OP_DIV = 3'd3;
  localparam opcode_t OP_INV = 3'd4;
  localparam opcode_t OP_NEG = 3'd5;

  localparam word_t MOD_RESET = word_t'(2);

  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    word_t room;
    room = m - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  function automatic word_t sub_mod(word_t x, word_t y, word_t m);
    return (x >= y) ? (x - y) : (x + (m - y));
  endfunction
endpackage
`default_nettype wire

[rtl/mau_if.sv]
// Handshake interfaces for the input, result and configuration channels.
`default_nettype none
interface mau_in_if;
  logic               valid;
  logic               ready;
  mau_pkg::opcode_t   operation;
  mau_pkg::word_t     operand_a;
  mau_pkg::word_t     operand_b;
  modport source(output valid, operation, operand_a, operand_b, input ready);
  modport sink(input valid, operation, operand_a, operand_b, output ready);
endinterface

interface mau_out_if;
  logic           valid;
  logic           ready;
  mau_pkg::word_t result;
  logic           no_inverse;
  modport source(output valid, result, no_inverse, input ready);
  modport sink(input valid, result, no_inverse, output ready);
endinterface

interface mau_cfg_if;
  logic           valid;
  logic           ready;
  mau_pkg::word_t modulus;
  modport source(output valid, modulus, input ready);
  modport sink(input valid, modulus, output ready);
endinterface
`default_nettype wire

[rtl/mau_reduce.sv]
// Bit-serial restoring reduction of one operand modulo the modulus.
`default_nettype none
module mau_reduce (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mau_pkg::word_t value,
  input  mau_pkg::word_t m,
  output logic           busy,
  output mau_pkg::word_t res
);
  import mau_pkg::*;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            sh_r, sh_nxt;
  word_t            rem_r, rem_nxt;
  logic [W:0]       trial;

  always_comb begin
    trial    = {rem_r, sh_r[W-1]};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = value;
      rem_nxt  = '0;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[W-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, m}) ? W'(trial - {1'b0, m}) : trial[W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign res  = rem_r;
endmodule
`default_nettype wire

[rtl/mau_engine.sv]
// Sequencer with the serial modular multiplier and the extended Euclidean inverse.
`default_nettype none
module mau_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              take,
  input  mau_pkg::opcode_t  op,
  input  mau_pkg::word_t    a,
  input  mau_pkg::word_t    b,
  input  mau_pkg::word_t    m,
  output mau_pkg::eng_stat_t stat,
  output mau_pkg::word_t    res,
  output logic              no_inv
);
  import mau_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RED   = 11'b00000000010,
    S_OPSEL = 11'b00000000100,
    S_MDBL  = 11'b00000001000,
    S_MADD  = 11'b00000010000,
    S_ETEST = 11'b00000100000,
    S_EALGN = 11'b00001000000,
    S_EDBL  = 11'b00010000000,
    S_EADD  = 11'b00100000000,
    S_EUPD  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t           state_r, state_nxt;
  opcode_t          op_r, op_nxt;
  logic             div_r, div_nxt;
  logic             q_r, q_nxt;
  logic             flag_r, flag_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t res_r, res_nxt, acc_r, acc_nxt, x_r, x_nxt, y_r, y_nxt;
  word_t r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  word_t rem_r, rem_nxt, d_r, d_nxt;
  word_t red_a, red_b, acc_dbl, acc_madd, acc_eadd;
  logic  busy_a, busy_b, red_start;

  mau_reduce u_red_a (.clk, .rst_n, .start(red_start), .value(a), .m,
                      .busy(busy_a), .res(red_a));
  mau_reduce u_red_b (.clk, .rst_n, .start(red_start), .value(b), .m,
                      .busy(busy_b), .res(red_b));

  always_comb begin
    acc_dbl  = add_mod(acc_r, acc_r, m);
    acc_madd = y_r[W-1] ? add_mod(acc_r, x_r, m) : acc_r;
    acc_eadd = q_r ? add_mod(acc_r, t1_r, m) : acc_r;
    state_nxt = state_r;
    op_nxt = op_r;  div_nxt = div_r;  q_nxt = q_r;  flag_nxt = flag_r;
    cnt_nxt = cnt_r;  res_nxt = res_r;  acc_nxt = acc_r;  x_nxt = x_r;
    y_nxt = y_r;  r0_nxt = r0_r;  r1_nxt = r1_r;  t0_nxt = t0_r;
    t1_nxt = t1_r;  rem_nxt = rem_r;  d_nxt = d_r;
    red_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = op;
          flag_nxt = 1'b0;
          if (m < word_t'(2)) begin
            res_nxt   = '0;
            flag_nxt  = (op == OP_DIV) || (op == OP_INV);
            state_nxt = S_DONE;
          end else begin
            red_start = 1'b1;
            state_nxt = S_RED;
          end
        end
      end
      S_RED: begin
        if (!busy_a && !busy_b) begin
          state_nxt = S_OPSEL;
        end
      end
      S_OPSEL: begin
        r0_nxt = m;
        t0_nxt = '0;
        t1_nxt = word_t'(1);
        acc_nxt = '0;
        cnt_nxt = CNT_W'(W - 1);
        state_nxt = S_DONE;
        case (op_r)
          OP_ADD: res_nxt = add_mod(red_a, red_b, m);
          OP_SUB: res_nxt = sub_mod(red_a, red_b, m);
          OP_NEG: res_nxt = sub_mod('0, red_a, m);
          OP_MUL: begin
            x_nxt = red_a;
            y_nxt = red_b;
            state_nxt = S_MDBL;
          end
          OP_DIV: begin
            div_nxt = 1'b1;
            r1_nxt = red_b;
            state_nxt = S_ETEST;
          end
          OP_INV: begin
            div_nxt = 1'b0;
            r1_nxt = red_a;
            state_nxt = S_ETEST;
          end
          default: res_nxt = '0;
        endcase
      end
      S_MDBL: begin
        acc_nxt = acc_dbl;
        state_nxt = S_MADD;
      end
      S_MADD: begin
        acc_nxt = acc_madd;
        y_nxt = {y_r[W-2:0], 1'b0};
        if (cnt_r == '0) begin
          res_nxt = acc_madd;
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_MDBL;
        end
      end
      S_ETEST: begin
        if (r1_r == '0) begin
          if (r0_r != word_t'(1)) begin
            flag_nxt = 1'b1;
            res_nxt = '0;
            state_nxt = S_DONE;
          end else if (div_r) begin
            x_nxt = red_a;
            y_nxt = t0_r;
            acc_nxt = '0;
            cnt_nxt = CNT_W'(W - 1);
            state_nxt = S_MDBL;
          end else begin
            res_nxt = t0_r;
            state_nxt = S_DONE;
          end
        end else begin
          d_nxt = r1_r;
          rem_nxt = r0_r;
          cnt_nxt = '0;
          acc_nxt = '0;
          state_nxt = S_EALGN;
        end
      end
      S_EALGN: begin
        if ({d_r, 1'b0} <= {1'b0, rem_r}) begin
          d_nxt = {d_r[W-2:0], 1'b0};
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = S_EDBL;
        end
      end
      S_EDBL: begin
        acc_nxt = acc_dbl;
        if (d_r <= rem_r) begin
          rem_nxt = rem_r - d_r;
          q_nxt = 1'b1;
        end else begin
          q_nxt = 1'b0;
        end
        state_nxt = S_EADD;
      end
      S_EADD: begin
        acc_nxt = acc_eadd;
        d_nxt = {1'b0, d_r[W-1:1]};
        if (cnt_r == '0) begin
          state_nxt = S_EUPD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_EDBL;
        end
      end
      S_EUPD: begin
        t1_nxt = sub_mod(t0_r, acc_r, m);
        t0_nxt = t1_r;
        r0_nxt = r1_r;
        r1_nxt = rem_r;
        state_nxt = S_ETEST;
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    op_r <= op_nxt;  div_r <= div_nxt;  q_r <= q_nxt;  flag_r <= flag_nxt;
    cnt_r <= cnt_nxt;  res_r <= res_nxt;  acc_r <= acc_nxt;  x_r <= x_nxt;
    y_r <= y_nxt;  r0_r <= r0_nxt;  r1_r <= r1_nxt;  t0_r <= t0_nxt;
    t1_r <= t1_nxt;  rem_r <= rem_nxt;  d_r <= d_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign res = res_r;
  assign no_inv = flag_r;
endmodule
`default_nettype wire

[rtl/modular_arithmetic_unit.sv]
// Top level of the modular arithmetic unit with channels, modulus register and result register.
// The unit works on one item at a time. Both operands are first reduced bit-serially. Add,
// subtract and negate then finish in the select state; multiply goes through a double and
// an add state per operand bit of the shared shift-and-add multiplier. Inverse runs the
// extended Euclidean algorithm: each division step tests the remainder, aligns the divisor,
// takes a double and an add state per quotient bit and updates remainders and coefficients,
// and a final test ends the loop; divide then adds one multiply. A modulus below two skips
// the reduction and goes straight to done. A finished result moves into the output register
// once that register is free or being read, and waits there while the next item is accepted.
`default_nettype none
module modular_arithmetic_unit (
  input  logic      clk,
  input  logic      rst_n,
  mau_in_if.sink    in_ch,
  mau_out_if.source out_ch,
  mau_cfg_if.sink   cfg_ch
);
  import mau_pkg::*;

  word_t     modulus_r, modulus_nxt;
  logic      out_valid_r, out_valid_nxt;
  word_t     result_r, result_nxt;
  logic      no_inv_r, no_inv_nxt;
  eng_stat_t stat;
  word_t     eng_res;
  logic      eng_flag, accept, take;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = stat.idle;
  assign accept = in_ch.valid && in_ch.ready;
  assign take   = stat.done && (!out_valid_r || out_ch.ready);

  mau_engine u_engine (
    .clk, .rst_n, .start(accept), .take, .op(in_ch.operation),
    .a(in_ch.operand_a), .b(in_ch.operand_b), .m(modulus_r),
    .stat, .res(eng_res), .no_inv(eng_flag)
  );

  always_comb begin
    modulus_nxt   = (cfg_ch.valid) ? cfg_ch.modulus : modulus_r;
    out_valid_nxt = out_valid_r;
    result_nxt    = result_r;
    no_inv_nxt    = no_inv_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      result_nxt    = eng_res;
      no_inv_nxt    = eng_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      modulus_r   <= modulus_nxt;
      out_valid_r <= out_valid_nxt;
    end
    result_r <= result_nxt;
    no_inv_r <= no_inv_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.result     = result_r;
  assign out_ch.no_inverse = no_inv_r;

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.no_inverse |-> out_ch.result == '0)
    else $error("result not zero with missing inverse");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second item accepted while busy");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> stat.idle && out_valid_r)
    else $error("result handoff lost");
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the modular arithmetic unit with a queue-fed driver and a checking monitor.
module testbench;
  import mau_pkg::*;

  typedef struct {
    opcode_t op;
    word_t   a;
    word_t   b;
  } request_t;

  typedef struct {
    word_t result;
    logic  no_inverse;
  } answer_t;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   errors;
  logic calm;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  word_t    modulus_shadow;

  mau_in_if  in_ch();
  mau_out_if out_ch();
  mau_cfg_if cfg_ch();

  modular_arithmetic_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [63:0] addm(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] room;
    room = m - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  function automatic logic [63:0] subm(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    return (x >= y) ? (x - y) : (x + (m - y));
  endfunction

  function automatic logic [63:0] mulm(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] acc;
    acc = 0;
    for (int i = 63; i >= 0; i--) begin
      acc = addm(acc, acc, m);
      if (y[i]) begin
        acc = addm(acc, x, m);
      end
    end
    return acc;
  endfunction

  function automatic logic invm(logic [63:0] x, logic [63:0] m, output logic [63:0] inv);
    logic [63:0] r0, r1, t0, t1, q, rn, tn;
    r0 = m;
    r1 = x;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      rn = r0 % r1;
      tn = subm(t0, mulm(q % m, t1, m), m);
      r0 = r1;
      r1 = rn;
      t0 = t1;
      t1 = tn;
    end
    inv = (r0 == 1) ? t0 : 64'd0;
    return r0 == 1;
  endfunction

  function automatic answer_t predict_answer(request_t rq, word_t modulus);
    answer_t ans;
    logic [63:0] m, a, b, iv;
    ans.result = '0;
    ans.no_inverse = 1'b0;
    m = modulus;
    if (m < 2) begin
      ans.no_inverse = (rq.op == OP_DIV || rq.op == OP_INV);
    end else begin
      a = rq.a % m;
      b = rq.b % m;
      case (rq.op)
        OP_ADD: ans.result = word_t'(addm(a, b, m));
        OP_SUB: ans.result = word_t'(subm(a, b, m));
        OP_MUL: ans.result = word_t'(mulm(a, b, m));
        OP_DIV: begin
          if (invm(b, m, iv)) ans.result = word_t'(mulm(a, iv, m));
          else ans.no_inverse = 1'b1;
        end
        OP_INV: begin
          if (invm(a, m, iv)) ans.result = word_t'(iv);
          else ans.no_inverse = 1'b1;
        end
        OP_NEG: ans.result = word_t'(subm(0, a, m));
        default: ;
      endcase
    end
    return ans;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s at cycle %0d: got %0h, want %0h", what, cycle_count, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    calm <= (cycle_count > 20000 && cycle_count < 60000);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_answers.push_back(predict_answer('{in_ch.operation, in_ch.operand_a,
                                                    in_ch.operand_b}, modulus_shadow));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
          in_ch.valid <= 1'b1;
          in_ch.operation <= pending_requests[0].op;
          in_ch.operand_a <= pending_requests[0].a;
          in_ch.operand_b <= pending_requests[0].b;
          void'(pending_requests.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || $urandom_range(99) >= 22;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected item", out_ch.result, 0);
        end else begin
          want = expected_answers.pop_front();
          if (out_ch.result !== want.result)
            report_mismatch("result", out_ch.result, want.result);
          if (out_ch.no_inverse !== want.no_inverse)
            report_mismatch("no_inverse", out_ch.no_inverse, want.no_inverse);
        end
      end
    end
  end

  task automatic write_modulus(word_t value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.modulus <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    modulus_shadow = value;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && !in_ch.valid && expected_answers.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic push_request(opcode_t op, word_t a, word_t b);
    pending_requests.push_back('{op, a, b});
  endtask

  function automatic word_t pick_operand(word_t m);
    int sel;
    sel = $urandom_range(9);
    if (m < 2 || sel == 0) return $urandom;
    if (sel == 1) return m - 1;
    if (sel == 2) return $urandom_range(1, 0);
    return $urandom % m;
  endfunction

  initial begin
    word_t moduli[9];
    word_t m;
    opcode_t op;
    moduli = '{32'd2, 32'hFFFFFFFF, 32'hFFFFFFFB, 32'd7, 32'd1, 32'd65521,
               32'h80000000, 32'd0, 32'd0};
    errors = 0;
    cycle_count = 0;
    calm = 1'b0;
    modulus_shadow = MOD_RESET;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.modulus = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_request(OP_ADD, 1, 1);
    push_request(OP_INV, 1, 0);
    push_request(OP_DIV, 1, 0);
    drain();
    write_modulus(32'hFFFFFFFB);
    for (int i = 0; i < 6; i++) push_request(opcode_t'(i), 0, 0);
    for (int i = 0; i < 6; i++) push_request(opcode_t'(i), 32'hFFFFFFFF, 32'hFFFFFFFA);
    push_request(OP_INV, 1, 0);
    push_request(OP_NEG, 32'hFFFFFFFA, 0);
    push_request(opcode_t'(6), 5, 5);
    push_request(opcode_t'(7), 5, 5);
    drain();
    write_modulus(0);
    push_request(OP_DIV, 3, 4);
    push_request(OP_ADD, 3, 4);
    drain();
    write_modulus(1);
    push_request(OP_INV, 3, 4);
    push_request(OP_MUL, 3, 4);
    drain();

    moduli[8] = $urandom;
    for (int p = 0; p < 9; p++) begin
      m = moduli[p];
      if (p == 7) m = $urandom | 32'h1;
      write_modulus(m);
      for (int i = 0; i < 95; i++) begin
        op = ($urandom_range(9) == 0) ? opcode_t'($urandom_range(7))
                                       : opcode_t'($urandom_range(5));
        push_request(op, pick_operand(m), pick_operand(m));
      end
      drain();
    end

    repeat (2000) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[files.f]
rtl/mau_pkg.sv
rtl/mau_if.sv
rtl/mau_reduce.sv
rtl/mau_engine.sv
rtl/modular_arithmetic_unit.sv
tb/testbench.sv
